// File: rtl/sit_pkg.sv
// shared constants and types for the segment intersection test
package sit_pkg;

  // default coordinate width and limit fraction width
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned LIMIT_FRAC_DEF  = 16;

  // widest operand slice fed to one multiplier in the bound stage
  localparam int unsigned MUL_CHUNK = 32;

  // result stream packing: crossing in bit 0, parallel flag in bit 1
  localparam int unsigned OUT_TDATA_W = 8;

  // limit register reset values, Q0.16 (about 0.001 and 0.999)
  localparam logic [15:0] LOW_LIMIT_RST  = 16'd66;
  localparam logic [15:0] HIGH_LIMIT_RST = 16'd65471;

  // configuration register index
  typedef enum logic [0:0] {
    CFG_LOW_LIMIT  = 1'b0,
    CFG_HIGH_LIMIT = 1'b1
  } cfg_reg_e;

  // stage enables of the split multiplier
  typedef struct packed {
    logic part;
    logic sum;
  } mul_en_t;

endpackage

// File: rtl/segment_intersection_test.sv
// top level of the segment intersection test pipeline
//
// usage: one transaction on the s_axis channel carries both segments (eight
// signed coordinates packed in tdata, first segment start x in the lowest
// bits). for every input transaction exactly one result transaction leaves
// on m_axis: tdata bit 0 is the crossing bit, bit 1 the parallel flag.
// the cfg channel writes the two Q0.LIMIT_FRAC_BITS product limits (index 0
// low, index 1 high); cfg_ready_o is always high, and writes are meant to be
// made while no pair is in flight.
// pipeline: a pair passes nine register stages (differences, products, cross
// terms, sign normalize, range check plus partial products, squares, limit
// products, bounds, compare). throughput: one pair per cycle while the
// output is not stalled, set by the fully pipelined datapath with every
// multiplier stage registered.
// stall: a full stage holds while its successor is full and stalled, so
// bubbles are squeezed out and the input keeps accepting until all nine
// stages hold a pair; nothing is dropped or duplicated.
// reset: clears all stage valid bits and loads the limits with 66 and 65471.
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH     = sit_pkg::COORD_WIDTH_DEF,
  parameter int unsigned LIMIT_FRAC_BITS = sit_pkg::LIMIT_FRAC_DEF,
  localparam int unsigned InTdataW       = ((8 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [InTdataW-1:0]         s_axis_tdata_i,
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // from bit 0: crossing, parallel_flag, zero padding
  output logic [sit_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  sit_pkg::cfg_reg_e           cfg_index_i,
  input  logic [LIMIT_FRAC_BITS-1:0]  cfg_data_i
);
  import sit_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned F    = LIMIT_FRAC_BITS;
  localparam int unsigned DW   = 2 * W + 2;        // signed cross terms
  localparam int unsigned MW   = 2 * W + 1;        // their magnitude
  localparam int unsigned DDW  = 2 * MW;           // squares and ns*nt
  localparam int unsigned CH   = MUL_CHUNK;
  localparam int unsigned NCH  = (DDW + CH - 1) / CH;
  localparam int unsigned PADW = NCH * CH;
  localparam int unsigned CPW  = CH + F;
  localparam int unsigned BW   = DDW + F;          // scaled bounds
  localparam int unsigned NST  = 9;

  // ---------------- configuration registers ----------------
  logic [F-1:0] low_q, high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= F'(LOW_LIMIT_RST);
      high_q <= F'(HIGH_LIMIT_RST);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_LIMIT:  low_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage valid bits and enables ----------------
  // a stage loads when it is empty or its successor loads
  logic [NST:1]   v_q;
  logic [NST+1:1] en;
  logic [NST:1]   v_in;

  always_comb begin
    en[NST+1] = m_axis_tready_i;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NST-1:1], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[NST];

  // ---------------- stage 1: direction and offset vectors ----------------
  logic [W-1:0] c [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = s_axis_tdata_i[i*W +: W];
    end
  end

  logic signed [W:0] rx_q, ry_q, qx_q, qy_q, dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rx_q <= {c[2][W-1], c[2]} - {c[0][W-1], c[0]};
      ry_q <= {c[3][W-1], c[3]} - {c[1][W-1], c[1]};
      qx_q <= {c[6][W-1], c[6]} - {c[4][W-1], c[4]};
      qy_q <= {c[7][W-1], c[7]} - {c[5][W-1], c[5]};
      dx_q <= {c[0][W-1], c[0]} - {c[4][W-1], c[4]};
      dy_q <= {c[1][W-1], c[1]} - {c[5][W-1], c[5]};
    end
  end

  // ---------------- stage 2: the six products ----------------
  logic signed [DW-1:0] rxqy_q, qxry_q, rxdy_q, rydx_q, qxdy_q, qydx_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rxqy_q <= DW'(rx_q) * DW'(qy_q);
      qxry_q <= DW'(qx_q) * DW'(ry_q);
      rxdy_q <= DW'(rx_q) * DW'(dy_q);
      rydx_q <= DW'(ry_q) * DW'(dx_q);
      qxdy_q <= DW'(qx_q) * DW'(dy_q);
      qydx_q <= DW'(qy_q) * DW'(dx_q);
    end
  end

  // ---------------- stage 3: denominator and numerators ----------------
  logic signed [DW-1:0] den3_q, ns3_q, nt3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      den3_q <= rxqy_q - qxry_q;
      ns3_q  <= rxdy_q - rydx_q;
      nt3_q  <= qxdy_q - qydx_q;
    end
  end

  // ---------------- stage 4: make the denominator positive ----------------
  logic signed [DW-1:0] den4_q, ns4_q, nt4_q;
  logic                 par4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      par4_q <= (den3_q == '0);
      if (den3_q[DW-1]) begin
        den4_q <= -den3_q;
        ns4_q  <= -ns3_q;
        nt4_q  <= -nt3_q;
      end else begin
        den4_q <= den3_q;
        ns4_q  <= ns3_q;
        nt4_q  <= nt3_q;
      end
    end
  end

  // ---------------- stage 5: range check, partial products ----------------
  logic ok5_q, par5_q;
  logic range_ok;

  // both parameters inside [0,1] and a real denominator
  assign range_ok = !par4_q
                 && !ns4_q[DW-1] && (ns4_q <= den4_q)
                 && !nt4_q[DW-1] && (nt4_q <= den4_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ok5_q  <= range_ok;
      par5_q <= par4_q;
    end
  end

  // stages 5 and 6 of the square d*d and of ns*nt live in the split multipliers
  logic [DDW-1:0] dd6, pp6;
  mul_en_t        mul_en;

  assign mul_en = '{part: en[5], sum: en[6]};

  sit_split_mul #(
    .WIDTH (MW)
  ) u_den_sq (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (den4_q[MW-1:0]),
    .b_i   (den4_q[MW-1:0]),
    .p_o   (dd6)
  );

  sit_split_mul #(
    .WIDTH (MW)
  ) u_num_prod (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (ns4_q[MW-1:0]),
    .b_i   (nt4_q[MW-1:0]),
    .p_o   (pp6)
  );

  // ---------------- stage 6: flags follow the squares ----------------
  logic ok6_q, par6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      ok6_q  <= ok5_q;
      par6_q <= par5_q;
    end
  end

  // ---------------- stage 7: limits times slices of d*d ----------------
  logic [PADW-1:0] dd_pad;
  logic [CPW-1:0]  lo_part_q [NCH];
  logic [CPW-1:0]  hi_part_q [NCH];
  logic [DDW-1:0]  pp7_q;
  logic            ok7_q, par7_q;

  assign dd_pad = PADW'(dd6);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int i = 0; i < NCH; i++) begin
        lo_part_q[i] <= CPW'(dd_pad[i*CH +: CH]) * CPW'(low_q);
        hi_part_q[i] <= CPW'(dd_pad[i*CH +: CH]) * CPW'(high_q);
      end
      pp7_q  <= pp6;
      ok7_q  <= ok6_q;
      par7_q <= par6_q;
    end
  end

  // ---------------- stage 8: assemble the bounds ----------------
  logic [BW-1:0] lo_bound_d, hi_bound_d;
  logic [BW-1:0] lo_bound_q, hi_bound_q, pp8_q;
  logic          ok8_q, par8_q;

  always_comb begin
    lo_bound_d = '0;
    hi_bound_d = '0;
    for (int i = 0; i < NCH; i++) begin
      lo_bound_d = lo_bound_d + (BW'(lo_part_q[i]) << (i*CH));
      hi_bound_d = hi_bound_d + (BW'(hi_part_q[i]) << (i*CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      lo_bound_q <= lo_bound_d;
      hi_bound_q <= hi_bound_d;
      pp8_q      <= {pp7_q, {F{1'b0}}};
      ok8_q      <= ok7_q;
      par8_q     <= par7_q;
    end
  end

  // ---------------- stage 9: compare, output register ----------------
  logic crossing_q, parallel_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      crossing_q <= ok8_q && (lo_bound_q < pp8_q) && (pp8_q < hi_bound_q);
      parallel_q <= par8_q;
    end
  end

  assign m_axis_tdata_o = {{(OUT_TDATA_W-2){1'b0}}, parallel_q, crossing_q};

  // ---------------- assertions ----------------
  // a parallel pair never reports a crossing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("crossing reported for a parallel pair");

  // input is only held off when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // crossed limits leave no window for a crossing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (low_q >= high_q)) |-> !m_axis_tdata_o[0])
    else $error("crossing reported with an empty limit window");

endmodule

// File: rtl/sit_split_mul.sv
// two-stage unsigned multiplier built from half-width partial products
module sit_split_mul #(
  parameter int unsigned WIDTH = 33
) (
  input  logic                   clk_i,
  input  sit_pkg::mul_en_t       en_i,
  input  logic [WIDTH-1:0]       a_i,
  input  logic [WIDTH-1:0]       b_i,
  output logic [2*WIDTH-1:0]     p_o
);
  import sit_pkg::*;

  localparam int unsigned H  = (WIDTH + 1) / 2;
  localparam int unsigned HW = WIDTH - H;
  localparam int unsigned PW = 2 * WIDTH;

  logic [H-1:0]      al, bl;
  logic [HW-1:0]     ah, bh;
  logic [2*H-1:0]    ll_q;
  logic [H+HW-1:0]   lh_q, hl_q;
  logic [2*HW-1:0]   hh_q;
  logic [PW-1:0]     p_d, p_q;

  assign al = a_i[H-1:0];
  assign ah = a_i[WIDTH-1:H];
  assign bl = b_i[H-1:0];
  assign bh = b_i[WIDTH-1:H];

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      ll_q <= (2*H)'(al) * (2*H)'(bl);
      lh_q <= (H+HW)'(al) * (H+HW)'(bh);
      hl_q <= (H+HW)'(ah) * (H+HW)'(bl);
      hh_q <= (2*HW)'(ah) * (2*HW)'(bh);
    end
  end

  // recombine
  always_comb begin
    p_d = (PW'(hh_q) << (2*H)) + ((PW'(lh_q) + PW'(hl_q)) << H) + PW'(ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
